/* design/mlet_pkg.sv */
// Package with the shared types, sizes and codes of the line envelope table.
`default_nettype none
package mlet_pkg;
	localparam int MAX_LINES = 64;
	localparam int IDX_W = $clog2(MAX_LINES);
	localparam int CNT_W = $clog2(MAX_LINES + 1);
	localparam int BP_W = 35;
	localparam int DIV_W = 33;
	localparam logic signed [BP_W-1:0] POS_INF = 35'sd17179869183;
	localparam logic signed [BP_W-1:0] NEG_INF = -35'sd17179869183;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic command;
		logic signed [31:0] slope;
		logic signed [31:0] intercept;
		logic signed [31:0] query_x;
	} req_t;

	typedef struct packed {
		logic signed [63:0] value;
		logic [1:0] status;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0] slope;
		logic signed [31:0] intercept;
		logic signed [BP_W-1:0] breakpoint;
	} entry_t;
endpackage
`default_nettype wire

/* design/mlet_ram.sv */
// Simple dual-port synchronous RAM with a registered read.
`default_nettype none
module mlet_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input wire logic clk,
	input wire logic wr_en,
	input wire logic [AW-1:0] wr_addr,
	input wire logic [WIDTH-1:0] wr_data,
	input wire logic [AW-1:0] rd_addr,
	output logic [WIDTH-1:0] rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One write and one read each cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

/* design/mlet_div.sv */
// Bit-serial signed floor divider for breakpoint computation.
`default_nettype none
module mlet_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic signed [mlet_pkg::DIV_W-1:0] num,
	input wire logic signed [mlet_pkg::DIV_W-1:0] den,
	output logic done,
	output logic signed [mlet_pkg::BP_W-1:0] quot
);
	localparam int W = mlet_pkg::DIV_W;
	localparam int CW = $clog2(W + 1);

	logic [W-1:0] quo_q;
	logic [W-1:0] den_q;
	logic [W:0] rem_q;
	logic neg_q;
	logic busy_q;
	logic done_q;
	logic [CW-1:0] cnt_q;
	logic [W:0] trial;
	logic [mlet_pkg::BP_W-1:0] mag;

	assign trial = {rem_q[W-1:0], quo_q[W-1]};

	// Restoring division on magnitudes, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num[W-1] ? W'(-num) : num;
			den_q <= den[W-1] ? W'(-den) : den;
			rem_q <= '0;
			neg_q <= num[W-1] ^ den[W-1];
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	// Round toward minus infinity when the signs differ.
	assign mag = {{(mlet_pkg::BP_W - W){1'b0}}, quo_q};
	assign quot = neg_q ? $signed(-mag - {{(mlet_pkg::BP_W-1){1'b0}}, (rem_q != '0)})
		: $signed(mag);
	assign done = done_q;
endmodule
`default_nettype wire

/* design/max_line_envelope_table.sv */
// Top level of the line envelope table: sequencer, line memory and query datapath.
// Usage: a transaction on req either inserts a line (command 0) or asks for the
// maximum of slope*x + intercept at query_x (command 1). Every request gives
// exactly one transaction on rsp carrying value and status.
// The block works on one request at a time: req_stall is high from the cycle
// after acceptance until the result has been moved into the output register.
// Lines sit in one synchronous RAM with a registered read; all reads, shifts and
// rewrites of entries go through its single read and single write port.
// A query scans k <= n lines of an n-line table, reading each line and checking
// its breakpoint against query_x, then adds the product and intercept of the line
// it stops at to form the result.
// An insert first finds and opens its slot, then computes breakpoint cuts with
// the divider and removes entries from the table where a cut calls for it.
// The output register lets a new request be accepted while the previous
// result waits; when rsp_stall holds, the finished result stays in the
// sequencer until the output register frees up.
// Reset empties the table at once; no clearing pass is needed.
`default_nettype none
module max_line_envelope_table (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire mlet_pkg::req_t req,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output mlet_pkg::rsp_t rsp
);
	localparam int CW = mlet_pkg::CNT_W;
	localparam int AW = mlet_pkg::IDX_W;
	localparam int EW = $bits(mlet_pkg::entry_t);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_P_RD = 5'd1;
	localparam logic [4:0] S_P_CHK = 5'd2;
	localparam logic [4:0] S_SH_RD = 5'd3;
	localparam logic [4:0] S_SH_WR = 5'd4;
	localparam logic [4:0] S_M1 = 5'd5;
	localparam logic [4:0] S_M1_RET = 5'd6;
	localparam logic [4:0] S_M2 = 5'd7;
	localparam logic [4:0] S_M2_RET = 5'd8;
	localparam logic [4:0] S_M2_CUT2 = 5'd9;
	localparam logic [4:0] S_M3 = 5'd10;
	localparam logic [4:0] S_M3_RB = 5'd11;
	localparam logic [4:0] S_M3_CMP = 5'd12;
	localparam logic [4:0] S_M3_AFTER = 5'd13;
	localparam logic [4:0] S_C_RDA = 5'd14;
	localparam logic [4:0] S_C_RDB = 5'd15;
	localparam logic [4:0] S_C_GOT = 5'd16;
	localparam logic [4:0] S_C_DEC = 5'd17;
	localparam logic [4:0] S_C_DIV = 5'd18;
	localparam logic [4:0] S_C_WR = 5'd19;
	localparam logic [4:0] S_R_RD = 5'd20;
	localparam logic [4:0] S_R_WR = 5'd21;
	localparam logic [4:0] S_Q_RD = 5'd22;
	localparam logic [4:0] S_Q_CHK = 5'd23;
	localparam logic [4:0] S_Q_ADD = 5'd24;
	localparam logic [4:0] S_DONE = 5'd25;

	logic [4:0] state_q;
	logic [4:0] ret_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] x_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] ca_q;
	logic [CW-1:0] cb_q;
	logic beyond_q;
	logic flag_q;
	logic signed [31:0] k_q;
	logic signed [31:0] m_q;
	logic signed [31:0] qx_q;
	mlet_pkg::entry_t ea_q;
	mlet_pkg::entry_t eb_q;
	logic signed [mlet_pkg::BP_W-1:0] bp_q;
	logic signed [63:0] prod_s1;
	mlet_pkg::rsp_t res_q;
	mlet_pkg::rsp_t rsp_q;
	logic rsp_valid_q;
	logic rsp_load;

	logic wr_en;
	logic [AW-1:0] wr_addr;
	mlet_pkg::entry_t wr_ent;
	logic [AW-1:0] rd_addr;
	logic [EW-1:0] rd_raw;
	mlet_pkg::entry_t rd_ent;

	logic div_start;
	logic div_done;
	logic signed [mlet_pkg::DIV_W-1:0] div_num;
	logic signed [mlet_pkg::DIV_W-1:0] div_den;
	logic signed [mlet_pkg::BP_W-1:0] div_quot;
	logic [CW-1:0] j_next;

	mlet_ram #(
		.WIDTH(EW),
		.DEPTH(mlet_pkg::MAX_LINES),
		.AW(AW)
	) u_ram (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_ent),
		.rd_addr(rd_addr),
		.rd_data(rd_raw)
	);
	assign rd_ent = mlet_pkg::entry_t'(rd_raw);

	// Breakpoint of line a against line b: (m_b - m_a) / (k_a - k_b), floored.
	assign div_num = mlet_pkg::DIV_W'(eb_q.intercept) - mlet_pkg::DIV_W'(ea_q.intercept);
	assign div_den = mlet_pkg::DIV_W'(ea_q.slope) - mlet_pkg::DIV_W'(eb_q.slope);
	assign div_start = (state_q == S_C_DEC) && !beyond_q && (ea_q.slope != eb_q.slope);

	mlet_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.done(div_done),
		.quot(div_quot)
	);

	assign j_next = j_q + 1'b1;

	// The finished result moves to the output register when that is free.
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	// Memory port addressing per state.
	always_comb begin
		rd_addr = j_q[AW-1:0];
		wr_en = 1'b0;
		wr_addr = j_q[AW-1:0];
		wr_ent = rd_ent;
		case (state_q)
			S_SH_RD: begin
				rd_addr = AW'(j_q - 1'b1);
				if (j_q == pos_q) begin
					wr_en = 1'b1;
					wr_addr = pos_q[AW-1:0];
					wr_ent.slope = k_q;
					wr_ent.intercept = m_q;
					wr_ent.breakpoint = '0;
				end
			end
			S_SH_WR: begin
				wr_en = 1'b1;
			end
			S_M3: rd_addr = AW'(x_q - 1'b1);
			S_M3_RB: rd_addr = x_q[AW-1:0];
			S_C_RDA: rd_addr = ca_q[AW-1:0];
			S_C_RDB: rd_addr = cb_q[AW-1:0];
			S_C_WR: begin
				wr_en = 1'b1;
				wr_addr = ca_q[AW-1:0];
				wr_ent = ea_q;
				wr_ent.breakpoint = bp_q;
			end
			S_R_RD: rd_addr = j_next[AW-1:0];
			S_R_WR: wr_en = 1'b1;
			default: begin
			end
		endcase
	end

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						if (req.command == mlet_pkg::CMD_QUERY) begin
							state_q <= (cnt_q == '0) ? S_DONE : S_Q_RD;
						end else begin
							state_q <= (cnt_q == CW'(mlet_pkg::MAX_LINES)) ? S_DONE : S_P_RD;
						end
					end
				end
				S_P_RD: state_q <= (j_q == cnt_q) ? S_SH_RD : S_P_CHK;
				S_P_CHK: state_q <= (rd_ent.slope <= k_q) ? S_P_RD : S_SH_RD;
				S_SH_RD: begin
					if (j_q == pos_q) begin
						cnt_q <= cnt_q + 1'b1;
						state_q <= S_M1;
					end else begin
						state_q <= S_SH_WR;
					end
				end
				S_SH_WR: state_q <= S_SH_RD;
				S_M1: begin
					ret_q <= S_M1_RET;
					state_q <= S_C_RDA;
				end
				S_M1_RET: begin
					if (flag_q) begin
						ret_q <= S_M1;
						state_q <= S_R_RD;
					end else begin
						state_q <= S_M2;
					end
				end
				S_M2: begin
					if (pos_q != '0) begin
						ret_q <= S_M2_RET;
						state_q <= S_C_RDA;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_M2_RET: begin
					if (flag_q) begin
						ret_q <= S_M2_CUT2;
						state_q <= S_R_RD;
					end else begin
						state_q <= S_M3;
					end
				end
				S_M2_CUT2: begin
					ret_q <= S_M3;
					state_q <= S_C_RDA;
				end
				S_M3: state_q <= (x_q == '0) ? S_DONE : S_M3_RB;
				S_M3_RB: state_q <= S_M3_CMP;
				S_M3_CMP: begin
					if (ea_q.breakpoint >= rd_ent.breakpoint) begin
						ret_q <= S_M3_AFTER;
						state_q <= S_R_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_M3_AFTER: begin
					ret_q <= S_M3;
					state_q <= S_C_RDA;
				end
				S_C_RDA: state_q <= S_C_RDB;
				S_C_RDB: state_q <= S_C_GOT;
				S_C_GOT: state_q <= S_C_DEC;
				S_C_DEC: state_q <= div_start ? S_C_DIV : S_C_WR;
				S_C_DIV: state_q <= div_done ? S_C_WR : S_C_DIV;
				S_C_WR: state_q <= ret_q;
				S_R_RD: begin
					if (j_next >= cnt_q) begin
						cnt_q <= cnt_q - 1'b1;
						state_q <= ret_q;
					end else begin
						state_q <= S_R_WR;
					end
				end
				S_R_WR: state_q <= S_R_RD;
				S_Q_RD: state_q <= S_Q_CHK;
				S_Q_CHK: begin
					if ((j_next < cnt_q) && (rd_ent.breakpoint < mlet_pkg::BP_W'(qx_q))) begin
						state_q <= S_Q_RD;
					end else begin
						state_q <= S_Q_ADD;
					end
				end
				S_Q_ADD: state_q <= S_DONE;
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Index, operand and result registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				k_q <= req.slope;
				m_q <= req.intercept;
				qx_q <= req.query_x;
				j_q <= '0;
				res_q.value <= '0;
				if (req.command == mlet_pkg::CMD_QUERY) begin
					res_q.status <= (cnt_q == '0) ? mlet_pkg::ST_EMPTY : mlet_pkg::ST_OK;
				end else begin
					res_q.status <= (cnt_q == CW'(mlet_pkg::MAX_LINES))
						? mlet_pkg::ST_FULL : mlet_pkg::ST_OK;
				end
			end
			S_P_RD: begin
				if (j_q == cnt_q) begin
					pos_q <= j_q;
					j_q <= cnt_q;
				end
			end
			S_P_CHK: begin
				if (rd_ent.slope <= k_q) begin
					j_q <= j_next;
				end else begin
					pos_q <= j_q;
					j_q <= cnt_q;
				end
			end
			S_SH_WR: j_q <= j_q - 1'b1;
			S_M1: begin
				ca_q <= pos_q;
				cb_q <= pos_q + 1'b1;
			end
			S_M1_RET: j_q <= pos_q + 1'b1;
			S_M2: begin
				x_q <= (pos_q != '0) ? pos_q - 1'b1 : pos_q;
				ca_q <= pos_q - 1'b1;
				cb_q <= pos_q;
			end
			S_M2_RET: j_q <= pos_q;
			S_M2_CUT2: begin
				ca_q <= x_q;
				cb_q <= pos_q;
			end
			S_M3_RB: ea_q <= rd_ent;
			S_M3_CMP: j_q <= x_q;
			S_M3_AFTER: begin
				x_q <= x_q - 1'b1;
				ca_q <= x_q - 1'b1;
				cb_q <= x_q;
			end
			S_C_RDB: ea_q <= rd_ent;
			S_C_GOT: begin
				eb_q <= rd_ent;
				beyond_q <= (cb_q >= cnt_q);
			end
			S_C_DEC: begin
				if (beyond_q) begin
					bp_q <= mlet_pkg::POS_INF;
				end else if (ea_q.slope == eb_q.slope) begin
					bp_q <= (ea_q.intercept > eb_q.intercept) ? mlet_pkg::POS_INF
						: mlet_pkg::NEG_INF;
				end
			end
			S_C_DIV: begin
				if (div_done) begin
					bp_q <= div_quot;
				end
			end
			S_C_WR: flag_q <= !beyond_q && (bp_q >= eb_q.breakpoint);
			S_R_WR: j_q <= j_next;
			S_Q_CHK: begin
				if ((j_next < cnt_q) && (rd_ent.breakpoint < mlet_pkg::BP_W'(qx_q))) begin
					j_q <= j_next;
				end else begin
					prod_s1 <= 64'(rd_ent.slope) * 64'(qx_q);
					ea_q <= rd_ent;
				end
			end
			S_Q_ADD: res_q.value <= prod_s1 + 64'(ea_q.intercept);
			default: begin
			end
		endcase
	end

	// Output valid flag: set on a load, cleared once the result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
endmodule
`default_nettype wire
